// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	`ASSERT_PROP(lbl, clk, rstn, !(cond), msg)
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== src/ladsr_pkg.sv =====
`default_nettype none

package ladsr_pkg;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 18;
	localparam int LVL_W      = 16;
	localparam int CNT_W      = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// Divider: quotient is always below 2^16, numerator is level * offset
	localparam int QUO_W = 16;
	localparam int NUM_W = LVL_W + LEN_W;

	// Q1.15 unity and level reset values
	localparam logic [LVL_W-1:0] Q_ONE        = 16'h8000;
	localparam logic [LVL_W-1:0] SUS_LVL_RST  = 16'h4000;
	localparam logic [LVL_W-1:0] PEAK_LVL_RST = 16'h8000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK  = 3'd0,
		CFG_DECAY   = 3'd1,
		CFG_SUSTAIN = 3'd2,
		CFG_RELEASE = 3'd3,
		CFG_SUS_LVL = 3'd4,
		CFG_PEAK    = 3'd5
	} cfg_idx_t;

	// Configuration as seen by the sequencer, with segment ends precomputed
	typedef struct packed {
		logic [LEN_W-1:0] att_len;
		logic [LEN_W-1:0] dec_len;
		logic [LEN_W-1:0] rel_len;
		logic [CNT_W-1:0] end_att;
		logic [CNT_W-1:0] end_dec;
		logic [CNT_W-1:0] end_sus;
		logic [CNT_W-1:0] duration;
		logic [LVL_W-1:0] pk_lvl;
		logic [LVL_W-1:0] sus_lvl;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [LEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== src/ladsr_if.sv =====
`default_nettype none

// Sample channel
interface ladsr_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ladsr_pkg::SAMPLE_W-1:0] sample_in;
	logic                                 gate_enable;

	modport source(output valid, sample_in, gate_enable, input ready);
	modport sink(input valid, sample_in, gate_enable, output ready);
endinterface

// Result channel
interface ladsr_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ladsr_pkg::SAMPLE_W-1:0] sample_out;
	logic                                 envelope_done;

	modport source(output valid, sample_out, envelope_done, input ready);
	modport sink(input valid, sample_out, envelope_done, output ready);
endinterface

// Configuration write channel
interface ladsr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ladsr_pkg::CFG_IDX_W-1:0]  index;
	logic [ladsr_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/ladsr_cfg.sv =====
`default_nettype none

module ladsr_cfg #(
	parameter int SAMPLE_RATE = 48000
) (
	input  wire               clk,
	input  wire               arst_n,
	ladsr_cfg_if.sink         cfg_ch,
	output ladsr_pkg::cfg_t   cfg
);

	localparam int LW = ladsr_pkg::LEN_W;
	localparam int VW = ladsr_pkg::LVL_W;
	localparam int CW = ladsr_pkg::CNT_W;

	localparam logic [LW-1:0] ATT_RST = LW'(SAMPLE_RATE / 10);
	localparam logic [LW-1:0] DEC_RST = LW'(SAMPLE_RATE / 20);
	localparam logic [LW-1:0] SUS_RST = LW'((SAMPLE_RATE * 3) / 20);
	localparam logic [LW-1:0] REL_RST = LW'(SAMPLE_RATE / 20);

	logic [LW-1:0] att_q;
	logic [LW-1:0] dec_q;
	logic [LW-1:0] sus_len_q;
	logic [LW-1:0] rel_q;
	logic [VW-1:0] sus_lvl_q;
	logic [VW-1:0] pk_lvl_q;
	ladsr_pkg::cfg_t cfg_q;

	function automatic logic [VW-1:0] clamp_lvl(input logic [VW-1:0] v);
		clamp_lvl = (v > ladsr_pkg::Q_ONE) ? ladsr_pkg::Q_ONE : v;
	endfunction

	assign cfg_ch.ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q     <= ATT_RST;
			dec_q     <= DEC_RST;
			sus_len_q <= SUS_RST;
			rel_q     <= REL_RST;
			sus_lvl_q <= ladsr_pkg::SUS_LVL_RST;
			pk_lvl_q  <= ladsr_pkg::PEAK_LVL_RST;
		end else if (cfg_ch.valid) begin
			case (ladsr_pkg::cfg_idx_t'(cfg_ch.index))
				ladsr_pkg::CFG_ATTACK:  att_q     <= cfg_ch.data[LW-1:0];
				ladsr_pkg::CFG_DECAY:   dec_q     <= cfg_ch.data[LW-1:0];
				ladsr_pkg::CFG_SUSTAIN: sus_len_q <= cfg_ch.data[LW-1:0];
				ladsr_pkg::CFG_RELEASE: rel_q     <= cfg_ch.data[LW-1:0];
				ladsr_pkg::CFG_SUS_LVL: sus_lvl_q <= cfg_ch.data[VW-1:0];
				ladsr_pkg::CFG_PEAK:    pk_lvl_q  <= cfg_ch.data[VW-1:0];
				default: ;
			endcase
		end
	end

	// Segment boundaries and clamped levels, registered from the configuration registers
	always_ff @(posedge clk) begin
		cfg_q.att_len  <= att_q;
		cfg_q.dec_len  <= dec_q;
		cfg_q.rel_len  <= rel_q;
		cfg_q.end_att  <= CW'(att_q);
		cfg_q.end_dec  <= CW'(att_q) + CW'(dec_q);
		cfg_q.end_sus  <= CW'(att_q) + CW'(dec_q) + CW'(sus_len_q);
		cfg_q.duration <= CW'(att_q) + CW'(dec_q) + CW'(sus_len_q) + CW'(rel_q);
		cfg_q.pk_lvl   <= clamp_lvl(pk_lvl_q);
		cfg_q.sus_lvl  <= clamp_lvl(sus_lvl_q);
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/ladsr_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Requires num < den * 2^QUO_W, so the quotient fits in QUO_W bits.
module ladsr_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire ladsr_pkg::div_req_t   req,
	output ladsr_pkg::div_rsp_t        rsp
);

	localparam int QW = ladsr_pkg::QUO_W;
	localparam int DW = ladsr_pkg::LEN_W;
	localparam int SW = $clog2(QW + 1);
	localparam logic [SW-1:0] STEPS = SW'(QW);
	localparam logic [SW-1:0] LAST  = SW'(1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] lo_q;
	logic [DW-1:0] den_q;
	logic [SW-1:0] cnt_q;
	logic          done_q;
	logic [DW+1:0] trial;
	logic          fit;

	// Trial subtract of the divisor from the shifted remainder
	assign trial = {1'b0, rem_q, lo_q[QW-1]} - {2'b00, den_q};
	assign fit   = !trial[DW+1];

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= STEPS;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - LAST;
			done_q <= (cnt_q == LAST);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[ladsr_pkg::NUM_W-1:QW];
			lo_q  <= req.num[QW-1:0];
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			rem_q <= fit ? trial[DW-1:0] : {rem_q[DW-2:0], lo_q[QW-1]};
			lo_q  <= {lo_q[QW-2:0], fit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = lo_q;

endmodule

`default_nettype wire

// ===== src/linear_adsr_envelope_top.sv =====
// Linear one-shot ADSR envelope on a 16-bit sample stream. With gate_enable
// set, each sample is scaled by the Q1.15 envelope at the current sample
// count (rounded toward minus infinity) and the count advances, wrapping to
// zero and setting the sticky envelope_done flag at the end of the envelope.
// With gate_enable clear the sample passes unchanged. One sample is in work
// at a time: a scaled sample in attack, decay or release waits on the
// 16-step divider, a sustain sample skips the divider and a passed-through
// sample skips the scaling as well. The result register frees the input
// side as soon as it is loaded. Configuration writes reach the sequencer
// via the configuration registers and then the registered segment ends.
`default_nettype none
`include "assert_macros.svh"

module linear_adsr_envelope_top #(
	parameter int SAMPLE_RATE = 48000
) (
	input  wire          clk,
	input  wire          arst_n,
	ladsr_in_if.sink     sample_ch,
	ladsr_out_if.source  result_ch,
	ladsr_cfg_if.sink    cfg_ch
);

	localparam int SW = ladsr_pkg::SAMPLE_W;
	localparam int LW = ladsr_pkg::LEN_W;
	localparam int VW = ladsr_pkg::LVL_W;
	localparam int CW = ladsr_pkg::CNT_W;
	localparam int NW = ladsr_pkg::NUM_W;
	localparam int PW = 2*SW + 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CALC  = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_SCALE = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	state_t               state_q;
	ladsr_pkg::cfg_t      cfg;
	ladsr_pkg::div_req_t  div_req;
	ladsr_pkg::div_rsp_t  div_rsp;

	logic signed [SW-1:0] sample_q;
	logic                 gate_q;
	logic [CW-1:0]        count_q;
	logic                 done_q;
	logic [VW-1:0]        a_q;
	logic [LW-1:0]        t_q;
	logic [LW-1:0]        d_q;
	logic                 neg_q;
	logic [VW-1:0]        base_q;
	logic [VW-1:0]        env_q;
	logic signed [SW-1:0] res_q;
	logic                 out_valid_q;
	logic signed [SW-1:0] out_sample_q;
	logic                 out_done_q;

	logic [CW-1:0]        cnt_inc;
	logic [CW-1:0]        t_dec;
	logic [CW-1:0]        t_rel;
	logic                 in_range;
	logic                 out_load;
	logic signed [PW-1:0] scale_prod;

	ladsr_cfg #(
		.SAMPLE_RATE(SAMPLE_RATE)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	ladsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Segment decode helpers
	assign cnt_inc  = count_q + CW'(1);
	assign t_dec    = count_q - cfg.end_att;
	assign t_rel    = count_q - cfg.end_sus;
	assign in_range = count_q < cfg.duration;

	// Divider request: slope level times offset into the segment
	assign div_req.start = (state_q == ST_MUL);
	assign div_req.num   = NW'(a_q) * NW'(t_q);
	assign div_req.den   = d_q;

	// Final scaling, floor shift by 15
	assign scale_prod = PW'(sample_q) * PW'($signed({1'b0, env_q}));

	assign out_load        = (state_q == ST_WRITE) && (!out_valid_q || result_ch.ready);
	assign sample_ch.ready = (state_q == ST_IDLE);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sample_ch.valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (!gate_q || !in_range) begin
						state_q <= ST_WRITE;
					end else if (count_q < cfg.end_dec || count_q >= cfg.end_sus) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SCALE;
					end
					// advance the envelope position on gated samples
					if (gate_q) begin
						if (cnt_inc >= cfg.duration) begin
							count_q <= '0;
							done_q  <= 1'b1;
						end else begin
							count_q <= cnt_inc;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (sample_ch.valid) begin
					sample_q <= sample_ch.sample_in;
					gate_q   <= sample_ch.gate_enable;
				end
			end
			ST_CALC: begin
				res_q <= sample_q;
				if (count_q < cfg.end_att) begin
					a_q    <= cfg.pk_lvl;
					t_q    <= count_q[LW-1:0];
					d_q    <= cfg.att_len;
					neg_q  <= 1'b0;
					base_q <= '0;
				end else if (count_q < cfg.end_dec) begin
					a_q    <= (cfg.sus_lvl >= cfg.pk_lvl) ? cfg.sus_lvl - cfg.pk_lvl
					                                     : cfg.pk_lvl - cfg.sus_lvl;
					t_q    <= t_dec[LW-1:0];
					d_q    <= cfg.dec_len;
					neg_q  <= (cfg.sus_lvl < cfg.pk_lvl);
					base_q <= cfg.pk_lvl;
				end else begin
					a_q    <= cfg.sus_lvl;
					t_q    <= t_rel[LW-1:0];
					d_q    <= cfg.rel_len;
					neg_q  <= 1'b1;
					base_q <= cfg.sus_lvl;
				end
				env_q <= cfg.sus_lvl;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					env_q <= neg_q ? base_q - div_rsp.quo : base_q + div_rsp.quo;
				end
			end
			ST_SCALE: begin
				res_q <= scale_prod[2*SW-2:SW-1];
			end
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= res_q;
			out_done_q   <= done_q;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.sample_out    = out_sample_q;
	assign result_ch.envelope_done = out_done_q;

	// Checks
	`ASSERT_NEVER(a_div_done_in_div, clk, arst_n, div_rsp.done && (state_q != ST_DIV), "divider finished outside its state")
	`ASSERT_PROP(a_env_in_range, clk, arst_n, (state_q == ST_SCALE) |-> (env_q <= ladsr_pkg::Q_ONE), "envelope above unity")
	`ASSERT_PROP(a_done_sticky, clk, arst_n, $past(done_q) |-> done_q, "done flag cleared")

endmodule

`default_nettype wire
